FILE: sv/triangle_face_normal_top_assert.svh
// Assertion macros shared by the face normal design.
// Both macros sample on clock and are switched off during reset.
`ifndef TRIANGLE_FACE_NORMAL_TOP_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_TOP_ASSERT_SVH

// Same-cycle implication.
`define TFN_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TFN_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/tfn_pkg.sv
`timescale 1ns / 1ps

package tfn_pkg;

   // field widths
   localparam int COORD_WIDTH  = 16;
   localparam int NORMAL_WIDTH = 16;
   localparam int FRAC_BITS    = NORMAL_WIDTH - 2;

   // datapath widths
   localparam int EDGE_W    = COORD_WIDTH + 1;
   localparam int PROD_W    = 2 * EDGE_W;
   localparam int CROSS_W   = PROD_W + 1;
   localparam int MAG_IN_W  = CROSS_W;
   localparam int NORM_BITS = 31;
   localparam int JUST_RAW  = (MAG_IN_W > NORM_BITS) ? MAG_IN_W : NORM_BITS;
   localparam int JUST_W    = ((JUST_RAW + 7) / 8) * 8;
   localparam int GROUPS    = JUST_W / 8;
   localparam int ZG_W      = $clog2(GROUPS + 1);
   localparam int SQ_W      = 2 * NORM_BITS;
   localparam int SUM_W     = 64;
   localparam int ROOT_W    = 32;
   localparam int QUO_W     = FRAC_BITS + 2;
   localparam int NUM_W     = NORM_BITS + FRAC_BITS + 1;

   localparam logic [QUO_W-1:0] NORM_ONE = QUO_W'(1) << FRAC_BITS;
   localparam logic signed [NORMAL_WIDTH-1:0] NORM_POS = NORMAL_WIDTH'(1) << FRAC_BITS;
   localparam logic signed [NORMAL_WIDTH-1:0] NORM_NEG = -NORM_POS;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] v0_x;
      logic signed [COORD_WIDTH-1:0] v0_y;
      logic signed [COORD_WIDTH-1:0] v0_z;
      logic signed [COORD_WIDTH-1:0] v1_x;
      logic signed [COORD_WIDTH-1:0] v1_y;
      logic signed [COORD_WIDTH-1:0] v1_z;
      logic signed [COORD_WIDTH-1:0] v2_x;
      logic signed [COORD_WIDTH-1:0] v2_y;
      logic signed [COORD_WIDTH-1:0] v2_z;
   } req_type;

   typedef struct packed {
      logic signed [NORMAL_WIDTH-1:0] normal_x;
      logic signed [NORMAL_WIDTH-1:0] normal_y;
      logic signed [NORMAL_WIDTH-1:0] normal_z;
      logic                           degenerate;
   } rsp_type;

   // item data riding along the square root pipe
   typedef struct packed {
      logic [2:0][NORM_BITS-1:0] mag;
      logic [2:0]                neg;
      logic                      degen;
   } side_type;

   // item data of one divider step, three lanes
   typedef struct packed {
      logic [2:0][ROOT_W-1:0] rem;
      logic [2:0][QUO_W-1:0]  low;
      logic [2:0][QUO_W-1:0]  quo;
      logic [ROOT_W-1:0]      root;
      logic [2:0]             neg;
      logic                   degen;
   } div_type;

endpackage

FILE: sv/triangle_face_normal_top.sv
// channel  ports                         direction  item
// request  req_valid req_stall req_data  in         three vertices, Q3.12
// response rsp_valid rsp_stall rsp_data  out        unit normal Q1.14, flag
//
// One triangle enters per clock while req_stall is low; it passes the front stages first.
// The depth is set by the 32-step square root and the 16-step divider lanes.
// Reset clears every stage valid; no data registers are reset.
// A stall holds the result register; stages behind it keep filling bubbles.
`timescale 1ns / 1ps
`include "triangle_face_normal_top_assert.svh"

module triangle_face_normal_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tfn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tfn_pkg::rsp_type rsp_data
);

   localparam int FS = 8;
   localparam int EW = tfn_pkg::EDGE_W;
   localparam int PW = tfn_pkg::PROD_W;
   localparam int XW = tfn_pkg::CROSS_W;
   localparam int JW = tfn_pkg::JUST_W;
   localparam int NB = tfn_pkg::NORM_BITS;
   localparam int QW = tfn_pkg::QUO_W;
   localparam int FB = tfn_pkg::FRAC_BITS;
   localparam int RW = tfn_pkg::ROOT_W;
   localparam int UW = tfn_pkg::NUM_W;

   logic [FS-1:0] fv_ff;
   logic [FS:0]   en_f;

   logic signed [tfn_pkg::COORD_WIDTH-1:0] p0 [3];
   logic signed [tfn_pkg::COORD_WIDTH-1:0] p1 [3];
   logic signed [tfn_pkg::COORD_WIDTH-1:0] p2 [3];

   logic signed [EW-1:0] s1_e1_ff [3];
   logic signed [EW-1:0] s1_e2_ff [3];
   logic signed [PW-1:0] s2_p_ff [6];
   logic signed [XW-1:0] s3_c_ff [3];
   logic [JW-1:0]        s4_a_ff [3];
   logic [JW-1:0]        s4_a_in [3];
   logic [JW-1:0]        s4_m_ff;
   logic [2:0]           s4_neg_ff;
   logic                 s4_degen_ff;
   logic [JW-1:0]        s5_a_ff [3];
   logic [JW-1:0]        s5_m_ff;
   logic [2:0]           s5_neg_ff;
   logic                 s5_degen_ff;
   logic [tfn_pkg::ZG_W-1:0] zg;
   logic                 zg_done;
   logic [NB-1:0]        s6_mag_ff [3];
   logic [2:0]           s6_neg_ff;
   logic                 s6_degen_ff;
   logic [2:0]           lz;
   logic                 lz_done;
   logic [tfn_pkg::SQ_W-1:0] s7_sq_ff [3];
   logic [2:0]           s7_neg_ff;
   logic                 s7_degen_ff;
   logic [NB-1:0]        s7_mag_ff [3];
   logic [tfn_pkg::SUM_W-1:0] s8_sum_ff;
   tfn_pkg::side_type    s8_side_ff;

   logic                 sq_in_ready;
   logic                 sq_out_valid;
   logic                 sq_out_ready;
   logic [RW-1:0]        sq_root;
   tfn_pkg::side_type    sq_side;

   logic                 pv_ff;
   logic                 en_p;
   tfn_pkg::div_type     p_div_ff;
   tfn_pkg::div_type     p_div_in;
   logic [UW-1:0]        p_num [3];

   logic                 dv_in_ready;
   logic                 dv_out_valid;
   logic                 en_o;
   tfn_pkg::div_type     dv_out;

   logic                 rsp_valid_ff;
   tfn_pkg::rsp_type     rsp_data_ff;
   tfn_pkg::rsp_type     rsp_data_in;
   logic [QW-1:0]        sat [3];
   logic [QW-1:0]        comp [3];

   assign p0[0] = req_data.v0_x;
   assign p0[1] = req_data.v0_y;
   assign p0[2] = req_data.v0_z;
   assign p1[0] = req_data.v1_x;
   assign p1[1] = req_data.v1_y;
   assign p1[2] = req_data.v1_z;
   assign p2[0] = req_data.v2_x;
   assign p2[1] = req_data.v2_y;
   assign p2[2] = req_data.v2_z;

   // advance a front stage when it is empty or the next one advances
   always_comb begin
      en_f[FS] = sq_in_ready;
      for (int k = FS - 1; k >= 0; k--) begin
         en_f[k] = !fv_ff[k] || en_f[k+1];
      end
   end

   assign req_stall = !en_f[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else begin
         for (int k = 0; k < FS; k++) begin
            if (en_f[k]) begin
               fv_ff[k] <= (k == 0) ? req_valid : fv_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   // form the edge vectors
   always_ff @(posedge clock) begin
      if (en_f[0]) begin
         for (int i = 0; i < 3; i++) begin
            s1_e1_ff[i] <= EW'(p1[i]) - EW'(p0[i]);
            s1_e2_ff[i] <= EW'(p2[i]) - EW'(p0[i]);
         end
      end
   end

   // six partial products of the cross product
   always_ff @(posedge clock) begin
      if (en_f[1]) begin
         s2_p_ff[0] <= PW'(s1_e1_ff[1]) * PW'(s1_e2_ff[2]);
         s2_p_ff[1] <= PW'(s1_e1_ff[2]) * PW'(s1_e2_ff[1]);
         s2_p_ff[2] <= PW'(s1_e1_ff[2]) * PW'(s1_e2_ff[0]);
         s2_p_ff[3] <= PW'(s1_e1_ff[0]) * PW'(s1_e2_ff[2]);
         s2_p_ff[4] <= PW'(s1_e1_ff[0]) * PW'(s1_e2_ff[1]);
         s2_p_ff[5] <= PW'(s1_e1_ff[1]) * PW'(s1_e2_ff[0]);
      end
   end

   // cross product components
   always_ff @(posedge clock) begin
      if (en_f[2]) begin
         for (int i = 0; i < 3; i++) begin
            s3_c_ff[i] <= XW'(s2_p_ff[2*i]) - XW'(s2_p_ff[2*i+1]);
         end
      end
   end

   // magnitudes, signs and the zero test
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_a_in[i] = JW'(s3_c_ff[i][XW-1] ? XW'(-s3_c_ff[i]) : XW'(s3_c_ff[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (en_f[3]) begin
         for (int i = 0; i < 3; i++) begin
            s4_a_ff[i]   <= s4_a_in[i];
            s4_neg_ff[i] <= s3_c_ff[i][XW-1];
         end
         s4_m_ff     <= s4_a_in[0] | s4_a_in[1] | s4_a_in[2];
         s4_degen_ff <= (s4_a_in[0] | s4_a_in[1] | s4_a_in[2]) == '0;
      end
   end

   // count leading zero bytes of the largest magnitude
   always_comb begin
      zg      = '0;
      zg_done = 1'b0;
      for (int g = tfn_pkg::GROUPS - 1; g >= 0; g--) begin
         if (!zg_done) begin
            if (s4_m_ff[g*8 +: 8] != 8'd0) begin
               zg_done = 1'b1;
            end else begin
               zg = zg + tfn_pkg::ZG_W'(1);
            end
         end
      end
   end

   // coarse shift by whole bytes
   always_ff @(posedge clock) begin
      if (en_f[4]) begin
         for (int i = 0; i < 3; i++) begin
            s5_a_ff[i] <= s4_a_ff[i] << {zg, 3'b000};
         end
         s5_m_ff     <= s4_m_ff << {zg, 3'b000};
         s5_neg_ff   <= s4_neg_ff;
         s5_degen_ff <= s4_degen_ff;
      end
   end

   // count leading zeros in the top byte
   always_comb begin
      lz      = '0;
      lz_done = 1'b0;
      for (int b = 7; b >= 0; b--) begin
         if (!lz_done) begin
            if (s5_m_ff[JW-8+b]) begin
               lz_done = 1'b1;
            end else begin
               lz = lz + 3'd1;
            end
         end
      end
   end

   // fine shift, keep the top bits of the justified word
   always_ff @(posedge clock) begin
      if (en_f[5]) begin
         for (int i = 0; i < 3; i++) begin
            s6_mag_ff[i] <= NB'((s5_a_ff[i] << lz) >> (JW - NB));
         end
         s6_neg_ff   <= s5_neg_ff;
         s6_degen_ff <= s5_degen_ff;
      end
   end

   // squares
   always_ff @(posedge clock) begin
      if (en_f[6]) begin
         for (int i = 0; i < 3; i++) begin
            s7_sq_ff[i]  <= tfn_pkg::SQ_W'(s6_mag_ff[i]) * tfn_pkg::SQ_W'(s6_mag_ff[i]);
            s7_mag_ff[i] <= s6_mag_ff[i];
         end
         s7_neg_ff   <= s6_neg_ff;
         s7_degen_ff <= s6_degen_ff;
      end
   end

   // sum of squares
   always_ff @(posedge clock) begin
      if (en_f[7]) begin
         s8_sum_ff <= tfn_pkg::SUM_W'(s7_sq_ff[0]) + tfn_pkg::SUM_W'(s7_sq_ff[1])
                    + tfn_pkg::SUM_W'(s7_sq_ff[2]);
         for (int i = 0; i < 3; i++) begin
            s8_side_ff.mag[i] <= s7_mag_ff[i];
         end
         s8_side_ff.neg   <= s7_neg_ff;
         s8_side_ff.degen <= s7_degen_ff;
      end
   end

   tfn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fv_ff[FS-1]),
      .in_ready  (sq_in_ready),
      .in_sum    (s8_sum_ff),
      .in_side   (s8_side_ff),
      .out_valid (sq_out_valid),
      .out_ready (sq_out_ready),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // rounded dividends, split into a head below the root and the low bits
   always_comb begin
      p_div_in = '0;
      for (int i = 0; i < 3; i++) begin
         p_num[i] = (UW'(sq_side.mag[i]) << FB) + UW'(sq_root >> 1);
         p_div_in.rem[i] = RW'(p_num[i][UW-1:QW]);
         p_div_in.low[i] = p_num[i][QW-1:0];
      end
      p_div_in.root  = sq_root;
      p_div_in.neg   = sq_side.neg;
      p_div_in.degen = sq_side.degen;
   end

   assign en_p         = !pv_ff || dv_in_ready;
   assign sq_out_ready = en_p;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (en_p) begin
         pv_ff <= sq_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_p) begin
         p_div_ff <= p_div_in;
      end
   end

   tfn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pv_ff),
      .in_ready  (dv_in_ready),
      .in_div    (p_div_ff),
      .out_valid (dv_out_valid),
      .out_ready (en_o),
      .out_div   (dv_out)
   );

   // saturate to one, apply the sign, substitute the fallback normal
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sat[i]  = (dv_out.quo[i] > tfn_pkg::NORM_ONE) ? tfn_pkg::NORM_ONE : dv_out.quo[i];
         comp[i] = dv_out.neg[i] ? QW'(-sat[i]) : sat[i];
      end
      if (dv_out.degen) begin
         rsp_data_in.normal_x   = '0;
         rsp_data_in.normal_y   = tfn_pkg::NORM_POS;
         rsp_data_in.normal_z   = '0;
         rsp_data_in.degenerate = 1'b1;
      end else begin
         rsp_data_in.normal_x   = tfn_pkg::NORMAL_WIDTH'(comp[0]);
         rsp_data_in.normal_y   = tfn_pkg::NORMAL_WIDTH'(comp[1]);
         rsp_data_in.normal_z   = tfn_pkg::NORMAL_WIDTH'(comp[2]);
         rsp_data_in.degenerate = 1'b0;
      end
   end

   // result register; hold while stalled
   assign en_o = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_o) begin
         rsp_valid_ff <= dv_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_o) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TFN_ASSERT_IMP(a_degen_fallback, rsp_valid_ff && rsp_data_ff.degenerate, rsp_data_ff.normal_x == '0 && rsp_data_ff.normal_y == tfn_pkg::NORM_POS && rsp_data_ff.normal_z == '0, "degenerate item without fallback normal")
   `TFN_ASSERT_IMP(a_unit_range, rsp_valid_ff && !rsp_data_ff.degenerate, rsp_data_ff.normal_y <= tfn_pkg::NORM_POS && rsp_data_ff.normal_y >= tfn_pkg::NORM_NEG, "normal component beyond one")
   `TFN_ASSERT_IMP(a_root_floor, sq_out_valid && !sq_side.degen, sq_root[RW-1] || sq_root[RW-2], "square root below normalized range")
   `TFN_ASSERT_NXT(a_entry, req_valid && !req_stall, fv_ff[0], "accepted item missing from first stage")

endmodule

FILE: sv/tfn_sqrt.sv
`timescale 1ns / 1ps

module tfn_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [tfn_pkg::SUM_W-1:0]    in_sum,
   input  tfn_pkg::side_type            in_side,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [tfn_pkg::ROOT_W-1:0]   out_root,
   output tfn_pkg::side_type            out_side
);

   localparam int N  = tfn_pkg::ROOT_W;
   localparam int SW = tfn_pkg::SUM_W;
   localparam int TW = SW + 2;

   logic [N-1:0]   v_ff;
   logic [N-1:0]   v_src;
   logic [N:0]     en;
   logic [SW-1:0]  rem_ff [N];
   logic [SW-1:0]  rem_src [N];
   logic [SW-1:0]  rem_in [N];
   logic [N-1:0]   root_ff [N];
   logic [N-1:0]   root_src [N];
   logic [N-1:0]   root_in [N];
   tfn_pkg::side_type side_ff [N];
   tfn_pkg::side_type side_src [N];
   logic [TW-1:0]  trial [N];
   logic [N-1:0]   fits;

   // feed each step from the one before it
   always_comb begin
      rem_src[0]  = in_sum;
      root_src[0] = '0;
      side_src[0] = in_side;
      for (int k = 1; k < N; k++) begin
         rem_src[k]  = rem_ff[k-1];
         root_src[k] = root_ff[k-1];
         side_src[k] = side_ff[k-1];
      end
   end

   assign v_src = {v_ff[N-2:0], in_valid};

   // settle one root bit per step, most significant first
   always_comb begin
      for (int k = 0; k < N; k++) begin
         trial[k] = (TW'(root_src[k]) << (N - k)) + (TW'(1) << (2 * (N - 1 - k)));
         fits[k]  = trial[k] <= TW'(rem_src[k]);
         rem_in[k]  = fits[k] ? rem_src[k] - trial[k][SW-1:0] : rem_src[k];
         root_in[k] = fits[k] ? root_src[k] | (N'(1) << (N - 1 - k)) : root_src[k];
      end
   end

   // advance a step when it is empty or the next one advances
   always_comb begin
      en[N] = out_ready;
      for (int k = N - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_src[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (en[k]) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

FILE: sv/tfn_div.sv
`timescale 1ns / 1ps

module tfn_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  tfn_pkg::div_type in_div,
   output logic             out_valid,
   input  logic             out_ready,
   output tfn_pkg::div_type out_div
);

   localparam int N  = tfn_pkg::QUO_W;
   localparam int RW = tfn_pkg::ROOT_W;

   logic [N-1:0]     v_ff;
   logic [N-1:0]     v_src;
   logic [N:0]       en;
   tfn_pkg::div_type d_ff [N];
   tfn_pkg::div_type d_src [N];
   tfn_pkg::div_type d_in [N];
   logic [RW:0]      part [N][3];
   logic [N-1:0][2:0] ge;

   always_comb begin
      d_src[0] = in_div;
      for (int k = 1; k < N; k++) begin
         d_src[k] = d_ff[k-1];
      end
   end

   assign v_src = {v_ff[N-2:0], in_valid};

   // one restoring quotient bit per step in each lane
   always_comb begin
      for (int k = 0; k < N; k++) begin
         d_in[k] = d_src[k];
         for (int i = 0; i < 3; i++) begin
            part[k][i] = {d_src[k].rem[i], d_src[k].low[i][N-1]};
            ge[k][i]   = part[k][i] >= {1'b0, d_src[k].root};
            d_in[k].rem[i] = ge[k][i] ? RW'(part[k][i] - {1'b0, d_src[k].root})
                                      : part[k][i][RW-1:0];
            d_in[k].low[i] = {d_src[k].low[i][N-2:0], 1'b0};
            d_in[k].quo[i] = {d_src[k].quo[i][N-2:0], ge[k][i]};
         end
      end
   end

   // advance a step when it is empty or the next one advances
   always_comb begin
      en[N] = out_ready;
      for (int k = N - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_src[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (en[k]) begin
            d_ff[k] <= d_in[k];
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[N-1];
   assign out_div   = d_ff[N-1];

endmodule
